// ===== rtl/kect_pkg.sv =====
// Shared types and constants of the keyed event counter table.
package kect_pkg;

  localparam int unsigned SLOTS    = 16;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned CNT_W    = 64;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned IDX_W    = $clog2(SLOTS + 1);
  localparam int unsigned EXT_KEY_W  = 32;
  localparam int unsigned EXT_IDX_W  = 5;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 112;
  localparam int unsigned M_PAD_W    = M_TDATA_W - (EXT_IDX_W + 1 + EXT_KEY_W + PRIO_W + CNT_W);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [PRIO_W-1:0]   prio_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic {
    FUNC_ENQUEUE = 1'b0,
    FUNC_READ    = 1'b1
  } func_e;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
    logic              claim;
  } lookup_t;

endpackage

// ===== rtl/kect_lookup.sv =====
// Parallel match of all slots and selection of the first matching or empty slot.
module kect_lookup (
  input  logic [kect_pkg::SLOTS-1:0] slot_vld_i,
  input  kect_pkg::key_t             slot_key_i [kect_pkg::SLOTS],
  input  kect_pkg::prio_t            slot_prio_i [kect_pkg::SLOTS],
  input  kect_pkg::key_t             key_i,
  input  kect_pkg::prio_t            prio_i,
  output kect_pkg::lookup_t          lookup_o
);
  import kect_pkg::*;

  logic [SLOTS-1:0] hit;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = !slot_vld_i[i] || (slot_key_i[i] == key_i && slot_prio_i[i] == prio_i);
    end
  end

  always_comb begin
    lookup_o.found = |hit;
    lookup_o.idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        lookup_o.idx = SLOT_W'(i);
      end
    end
    lookup_o.claim = lookup_o.found && !slot_vld_i[lookup_o.idx];
  end

endmodule

// ===== rtl/keyed_event_counter_table_core.sv =====
// Top level of the keyed event counter table.
//
// Requests arrive on the s_axis channel. With tuser low a request records one
// event for its key and priority: the block matches all slots at once, claims
// the lowest empty slot when none matches, or falls back to the overflow slot
// when the table is full, and increments that slot's 64-bit counter. With
// tuser high a request reads the slot named by its read_slot field.
// Every request yields one result on the m_axis channel with the slot index,
// its valid flag, key, priority and the counter value after the request.
// Counters live in a 17-entry memory with a registered read. An accepted
// request enters the counter update register, and its result then moves
// to the output register; the counter read-modify-write sets the rate, as
// the request channel stays closed while a counter update is in flight, so
// no two accesses to the same entry overlap.
// Reset empties all slots and makes every counter read as zero.
// When the receiver stalls, the result waits in the output register; one
// further request may be taken and then waits until the result is taken.
module keyed_event_counter_table_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: event_key[31:0], event_priority[39:32], read_slot[44:40], zero fill
  input  logic [kect_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: func[0]
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: slot_index[4:0], slot_valid[5], slot_key[37:6], slot_priority[45:38],
  // event_count[109:46], zero fill
  output logic [kect_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import kect_pkg::*;

  logic [EXT_KEY_W-1:0] in_key_raw;
  key_t                 in_key;
  prio_t                in_prio;
  logic [EXT_IDX_W-1:0] in_slot;
  func_e                in_func;
  logic                 accept;

  logic [SLOTS-1:0] slot_vld_q;
  key_t             slot_key_q [SLOTS];
  prio_t            slot_prio_q [SLOTS];
  logic [SLOTS:0]   cnt_live_q;
  cnt_t             cnt_mem [SLOTS+1];
  cnt_t             cnt_rd_q;

  lookup_t lookup;

  logic [IDX_W-1:0] s1_idx;
  logic             s1_vld;
  key_t             s1_key;
  prio_t            s1_prio;
  logic             s1_live;
  logic             s1_in_range;

  logic             s2_valid_q;
  logic [IDX_W-1:0] s2_idx_q;
  logic             s2_vld_q;
  key_t             s2_key_q;
  prio_t            s2_prio_q;
  logic             s2_live_q;
  logic             s2_inc_q;
  logic             s2_fire;
  cnt_t             s2_cnt;

  logic                 m_valid_q;
  logic [EXT_IDX_W-1:0] m_idx_q;
  logic                 m_vld_q;
  logic [EXT_KEY_W-1:0] m_key_q;
  prio_t                m_prio_q;
  cnt_t                 m_cnt_q;

  assign in_key_raw = s_axis_tdata[EXT_KEY_W-1:0];
  assign in_key     = KEY_BITS'(in_key_raw);
  assign in_prio    = s_axis_tdata[EXT_KEY_W +: PRIO_W];
  assign in_slot    = s_axis_tdata[EXT_KEY_W + PRIO_W +: EXT_IDX_W];
  assign in_func    = func_e'(s_axis_tuser[0]);

  assign s_axis_tready = !s2_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  kect_lookup u_lookup (
    .slot_vld_i  (slot_vld_q),
    .slot_key_i  (slot_key_q),
    .slot_prio_i (slot_prio_q),
    .key_i       (in_key),
    .prio_i      (in_prio),
    .lookup_o    (lookup)
  );

  always_comb begin
    s1_idx      = '0;
    s1_vld      = 1'b0;
    s1_key      = '0;
    s1_prio     = '0;
    s1_in_range = 1'b0;
    unique case (in_func)
      FUNC_ENQUEUE: begin
        s1_in_range = 1'b1;
        if (lookup.found) begin
          s1_idx  = IDX_W'(lookup.idx);
          s1_vld  = 1'b1;
          s1_key  = in_key;
          s1_prio = in_prio;
        end else begin
          s1_idx = IDX_W'(SLOTS);
        end
      end
      FUNC_READ: begin
        s1_idx      = IDX_W'(in_slot);
        s1_in_range = in_slot <= EXT_IDX_W'(SLOTS);
        if (in_slot < EXT_IDX_W'(SLOTS) && slot_vld_q[in_slot[SLOT_W-1:0]]) begin
          s1_vld  = 1'b1;
          s1_key  = slot_key_q[in_slot[SLOT_W-1:0]];
          s1_prio = slot_prio_q[in_slot[SLOT_W-1:0]];
        end
      end
      default: ;
    endcase
    s1_live = s1_in_range && cnt_live_q[s1_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (accept && in_func == FUNC_ENQUEUE && lookup.claim) begin
      slot_vld_q[lookup.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_func == FUNC_ENQUEUE && lookup.claim) begin
      slot_key_q[lookup.idx]  <= in_key;
      slot_prio_q[lookup.idx] <= in_prio;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && s1_in_range) begin
      cnt_rd_q <= cnt_mem[s1_idx];
    end
    if (s2_fire && s2_inc_q) begin
      cnt_mem[s2_idx_q] <= s2_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_live_q <= '0;
    end else if (s2_fire && s2_inc_q) begin
      cnt_live_q[s2_idx_q] <= 1'b1;
    end
  end

  assign s2_fire = s2_valid_q && (!m_valid_q || m_axis_tready);
  assign s2_cnt  = (s2_live_q ? cnt_rd_q : '0) + CNT_W'(s2_inc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (accept) begin
      s2_valid_q <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_idx_q  <= s1_idx;
      s2_vld_q  <= s1_vld;
      s2_key_q  <= s1_key;
      s2_prio_q <= s1_prio;
      s2_live_q <= s1_live;
      s2_inc_q  <= in_func == FUNC_ENQUEUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s2_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      m_idx_q  <= EXT_IDX_W'(s2_idx_q);
      m_vld_q  <= s2_vld_q;
      m_key_q  <= EXT_KEY_W'(s2_key_q);
      m_prio_q <= s2_prio_q;
      m_cnt_q  <= s2_cnt;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, m_cnt_q, m_prio_q, m_key_q, m_vld_q, m_idx_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s2_valid_q && !s_axis_tready)
    else $error("accepted request did not enter the counter update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire |=> m_valid_q)
    else $error("counter update did not reach the output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((slot_vld_q & (slot_vld_q + SLOTS'(1))) == '0))
    else $error("slots did not fill in order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_vld_q |-> m_idx_q < EXT_IDX_W'(SLOTS))
    else $error("overflow or out of range slot reported as valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire && s2_inc_q |=> cnt_live_q[$past(s2_idx_q)])
    else $error("counter write did not mark the entry live");

endmodule
